### hdl/sparc_instruction_classifier_top_macros.svh
// assertion macros shared by the sparc instruction classifier rtl
`ifndef SPARC_INSTRUCTION_CLASSIFIER_TOP_MACROS_SVH
`define SPARC_INSTRUCTION_CLASSIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clk outside reset
`define SIC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked on every rising clk outside reset
`define SIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SIC_ASSERT_IMPLIES(label, ante, cons)
`define SIC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hdl/sic_pkg.sv
`timescale 1ns / 1ps
// types, class codes and fpop1 table for the sparc instruction classifier
package sic_pkg;

  localparam logic [3:0] CLS_INVALID = 4'd0;
  localparam logic [3:0] CLS_ALU     = 4'd1;
  localparam logic [3:0] CLS_MUL     = 4'd2;
  localparam logic [3:0] CLS_DIV     = 4'd3;
  localparam logic [3:0] CLS_BJ      = 4'd4;
  localparam logic [3:0] CLS_LOAD    = 4'd5;
  localparam logic [3:0] CLS_FENCE   = 4'd6;
  localparam logic [3:0] CLS_FPALU   = 4'd7;
  localparam logic [3:0] CLS_FPMUL   = 4'd8;
  localparam logic [3:0] CLS_FPDIV   = 4'd9;
  localparam logic [3:0] CLS_MAX     = CLS_FPDIV;

  localparam logic [3:0] SUB_INVALID  = 4'd0;
  localparam logic [3:0] SUB_NOP      = 4'd1;
  localparam logic [3:0] SUB_UNCOND   = 4'd2;
  localparam logic [3:0] SUB_COND     = 4'd3;
  localparam logic [3:0] SUB_CALL     = 4'd4;
  localparam logic [3:0] SUB_RET      = 4'd5;
  localparam logic [3:0] SUB_MEMORY   = 4'd6;
  localparam logic [3:0] SUB_MEMFENCE = 4'd7;
  localparam logic [3:0] SUB_FETCHOP  = 4'd8;
  localparam logic [3:0] SUB_MAX      = SUB_FETCHOP;

  // major opcode, bits 31..30
  localparam logic [1:0] OP_BRANCH = 2'd0;
  localparam logic [1:0] OP_CALL   = 2'd1;
  localparam logic [1:0] OP_ARITH  = 2'd2;

  // op3 codes of the arithmetic group
  localparam logic [5:0] OP3_RDSTATE = 6'h28;
  localparam logic [5:0] OP3_RDPR    = 6'h2a;
  localparam logic [5:0] OP3_FLUSHW  = 6'h2b;
  localparam logic [5:0] OP3_UMUL    = 6'h24;
  localparam logic [5:0] OP3_UDIV    = 6'h2d;
  localparam logic [5:0] OP3_RSV29   = 6'h29;
  localparam logic [5:0] OP3_RSV37   = 6'h37;
  localparam logic [5:0] OP3_FPOP1   = 6'h34;
  localparam logic [5:0] OP3_FPOP2   = 6'h35;
  localparam logic [5:0] OP3_JMPL    = 6'h38;
  localparam logic [5:0] OP3_RETURN  = 6'h39;
  localparam logic [5:0] OP3_TCC     = 6'h3a;
  localparam logic [5:0] OP3_DONE    = 6'h3e;
  localparam logic [5:0] OP3_ALU_END = 6'h20;
  localparam logic [5:0] OP3_ARITH_END = 6'h38;
  localparam logic [4:0] RS1_MEMBAR  = 5'd15;

  typedef struct packed {
    logic [3:0] op_class;
    logic [3:0] op_subclass;
    logic [4:0] dest_reg;
    logic [4:0] src1_reg;
    logic [4:0] src2_reg;
  } result_t;

  function automatic logic [3:0] fpop1_class(input logic [8:0] opf);
    logic [3:0] cls;
    cls = CLS_INVALID;
    case (opf)
      9'h001, 9'h005, 9'h009, 9'h041, 9'h042, 9'h043, 9'h045, 9'h046, 9'h047,
      9'h0c4, 9'h0c6, 9'h0c7, 9'h0c8, 9'h0c9, 9'h0cb, 9'h0cc, 9'h0cd, 9'h0ce,
      9'h0d1, 9'h0d2, 9'h0d3, 9'h002, 9'h006, 9'h00a, 9'h081, 9'h082, 9'h084,
      9'h088, 9'h003, 9'h007, 9'h00b, 9'h083, 9'h08c: cls = CLS_FPALU;
      9'h029, 9'h02a, 9'h02b, 9'h04d, 9'h04e, 9'h04f: cls = CLS_FPDIV;
      9'h049, 9'h04a, 9'h04b, 9'h069, 9'h06e: cls = CLS_FPMUL;
      default: cls = CLS_INVALID;
    endcase
    return cls;
  endfunction

endpackage

### hdl/sic_decode.sv
`timescale 1ns / 1ps
// combinational decision tree from instruction word to class and registers
module sic_decode (
  input  logic [31:0]      word,
  output sic_pkg::result_t res
);

  logic [1:0] op;
  logic [2:0] op2;
  logic [5:0] op3;
  logic [1:0] cc;
  logic [4:0] rd;
  logic [4:0] f_rs1;
  logic [4:0] f_rs2;
  logic       imm;
  logic [4:0] rs2sel;
  logic       listed;
  logic [3:0] cls;
  logic [3:0] sub;
  logic [4:0] rs1;
  logic [4:0] rs2;

  assign op     = word[31:30];
  assign op2    = word[24:22];
  assign op3    = word[24:19];
  assign cc     = word[21:20];
  assign rd     = word[29:25];
  assign f_rs1  = word[18:14];
  assign f_rs2  = word[4:0];
  assign imm    = word[13];
  assign rs2sel = imm ? 5'd0 : f_rs2;

  // memory op3 codes that get their own handling
  assign listed = (op3 inside {[6'h00:6'h03], [6'h08:6'h0d], [6'h0f:6'h13],
                               [6'h18:6'h1c], [6'h2d:6'h32], 6'h1f});

  always_comb begin
    cls = sic_pkg::CLS_INVALID;
    sub = sic_pkg::SUB_INVALID;
    rs1 = 5'd0;
    rs2 = 5'd0;
    case (op)
      sic_pkg::OP_BRANCH: begin
        cls = sic_pkg::CLS_BJ;
        case (op2)
          3'd1: begin
            if (cc == 2'd0) begin
              sub = sic_pkg::SUB_UNCOND;
            end else if (cc == 2'd2) begin
              sub = sic_pkg::SUB_COND;
            end
          end
          3'd3: begin
            rs1 = f_rs1;
            sub = sic_pkg::SUB_UNCOND;
          end
          3'd5, 3'd6: sub = sic_pkg::SUB_COND;
          3'd2: sub = sic_pkg::SUB_UNCOND;
          3'd4: begin
            // sethi, a nop only with rd of zero
            cls = sic_pkg::CLS_ALU;
            sub = (rd != 5'd0) ? sic_pkg::SUB_INVALID : sic_pkg::SUB_NOP;
          end
          default: sub = sic_pkg::SUB_INVALID;
        endcase
      end
      sic_pkg::OP_CALL: begin
        cls = sic_pkg::CLS_BJ;
        sub = sic_pkg::SUB_CALL;
      end
      sic_pkg::OP_ARITH: begin
        if (op3 == sic_pkg::OP3_TCC) begin
          rs1 = f_rs1;
          rs2 = rs2sel;
          cls = sic_pkg::CLS_BJ;
          sub = sic_pkg::SUB_UNCOND;
        end else if (op3 == sic_pkg::OP3_RDSTATE) begin
          rs1 = f_rs1;
          if (f_rs1 == sic_pkg::RS1_MEMBAR) begin
            cls = sic_pkg::CLS_FENCE;
            sub = sic_pkg::SUB_MEMFENCE;
          end else if (f_rs1 inside {5'd0, [5'd2:5'd6], [5'd16:5'd25]}) begin
            cls = sic_pkg::CLS_ALU;
          end
        end else if (op3 == sic_pkg::OP3_RDPR) begin
          cls = sic_pkg::CLS_ALU;
        end else if (op3 == sic_pkg::OP3_FLUSHW) begin
          cls = sic_pkg::CLS_FENCE;
          sub = sic_pkg::SUB_MEMFENCE;
        end else if (op3 == sic_pkg::OP3_FPOP1) begin
          rs1 = f_rs1;
          rs2 = f_rs2;
          cls = sic_pkg::fpop1_class(word[13:5]);
        end else if (op3 == sic_pkg::OP3_FPOP2) begin
          rs1 = f_rs1;
          rs2 = f_rs2;
          cls = sic_pkg::CLS_FPALU;
        end else if (op3 < sic_pkg::OP3_ARITH_END) begin
          rs1 = f_rs1;
          rs2 = rs2sel;
          if (op3 < sic_pkg::OP3_ALU_END) begin
            cls = sic_pkg::CLS_ALU;
          end else if (op3 == sic_pkg::OP3_UMUL) begin
            cls = sic_pkg::CLS_MUL;
          end else if (op3 == sic_pkg::OP3_UDIV) begin
            cls = sic_pkg::CLS_DIV;
          end else if (op3 == sic_pkg::OP3_RSV29 || op3 == sic_pkg::OP3_RSV37) begin
            cls = sic_pkg::CLS_INVALID;
          end else begin
            cls = sic_pkg::CLS_ALU;
          end
        end else if (op3 == sic_pkg::OP3_RETURN) begin
          rs1 = f_rs1;
          rs2 = rs2sel;
          cls = sic_pkg::CLS_BJ;
          sub = sic_pkg::SUB_RET;
        end else begin
          rs1 = f_rs1;
          rs2 = rs2sel;
          if (op3 == sic_pkg::OP3_JMPL) begin
            cls = sic_pkg::CLS_BJ;
            sub = sic_pkg::SUB_CALL;
          end else if (op3 == sic_pkg::OP3_DONE) begin
            cls = sic_pkg::CLS_BJ;
            sub = sic_pkg::SUB_UNCOND;
          end else if (op3 inside {[6'h3b:6'h3d]}) begin
            cls = sic_pkg::CLS_ALU;
          end
        end
      end
      default: begin
        // memory group: form sets the default, listed codes may override it, unlisted codes replace it
        rs1 = f_rs1;
        rs2 = rs2sel;
        if (imm) begin
          cls = sic_pkg::CLS_ALU;
          sub = sic_pkg::SUB_INVALID;
        end else begin
          cls = sic_pkg::CLS_LOAD;
          sub = sic_pkg::SUB_MEMORY;
        end
        if (listed) begin
          if (op3 inside {[6'h00:6'h03], [6'h08:6'h0b], 6'h0d, [6'h10:6'h13],
                          [6'h18:6'h1b], 6'h30, 6'h32}) begin
            cls = sic_pkg::CLS_LOAD;
            sub = sic_pkg::SUB_MEMORY;
          end else if (op3 inside {6'h0f, 6'h1f}) begin
            cls = sic_pkg::CLS_FENCE;
            sub = sic_pkg::SUB_FETCHOP;
          end else if (op3 == 6'h2d) begin
            cls = sic_pkg::CLS_ALU;
            sub = sic_pkg::SUB_NOP;
          end
        end else if (op3 inside {[6'h20:6'h23]}) begin
          cls = sic_pkg::CLS_LOAD;
          sub = sic_pkg::SUB_MEMORY;
        end else begin
          // stores and other unlisted memory codes
          cls = sic_pkg::CLS_FENCE;
          sub = sic_pkg::SUB_FETCHOP;
        end
      end
    endcase
  end

  assign res.op_class    = cls;
  assign res.op_subclass = sub;
  assign res.dest_reg    = rd;
  assign res.src1_reg    = rs1;
  assign res.src2_reg    = rs2;

endmodule

### hdl/sparc_instruction_classifier_top.sv
`timescale 1ns / 1ps
// top level of the sparc instruction classifier with input and result registers
//
// usage:
//   input channel: in_valid, in_stall, instruction_word. a request is taken at a
//   rising clk edge with in_valid high and in_stall low.
//   output channel: out_valid, out_stall and the fields op_class, op_subclass,
//   dest_reg, src1_reg, src2_reg. a result is taken with out_valid high and
//   out_stall low.
//   path: a request passes through the input register and then the result
//   register, with the decode tree between them; out_valid rises when the
//   result register loads, which out_stall on a held result can delay.
//   throughput: one request per cycle while in_stall is low, set by the single decode pass.
//   stall: while out_stall holds a result, the input register still takes one
//   more request; in_stall rises only when both registers are full.
//   reset: rst (synchronous, active high) empties both registers; nothing else
//   is kept, so the block is ready in the cycle after reset drops.
`include "sparc_instruction_classifier_top_macros.svh"

module sparc_instruction_classifier_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  op_class,
  output logic [3:0]  op_subclass,
  output logic [4:0]  dest_reg,
  output logic [4:0]  src1_reg,
  output logic [4:0]  src2_reg
);

  logic             s1_valid;
  logic [31:0]      s1_word;
  logic             res_valid;
  sic_pkg::result_t result;
  sic_pkg::result_t dec;
  logic             out_take;
  logic             in_take;

  sic_decode u_decode (
    .word (s1_word),
    .res  (dec)
  );

  // result register can load when empty or being drained
  assign out_take = !res_valid || !out_stall;
  assign in_stall = s1_valid && !out_take;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_take) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word <= instruction_word;
    end
    if (out_take && s1_valid) begin
      result <= dec;
    end
  end

  assign out_valid   = res_valid;
  assign op_class    = result.op_class;
  assign op_subclass = result.op_subclass;
  assign dest_reg    = result.dest_reg;
  assign src1_reg    = result.src1_reg;
  assign src2_reg    = result.src2_reg;

  `SIC_ASSERT_NEXT(a_take_fills_s1, in_take, s1_valid)
  `SIC_ASSERT_NEXT(a_s1_held, s1_valid && !out_take, s1_valid && $stable(s1_word))
  `SIC_ASSERT_NEXT(a_s1_moves_out, s1_valid && out_take, res_valid)
  `SIC_ASSERT_IMPLIES(a_stall_only_full, in_stall, s1_valid && res_valid)
  `SIC_ASSERT_IMPLIES(a_codes_in_range, res_valid,
                      op_class <= sic_pkg::CLS_MAX && op_subclass <= sic_pkg::SUB_MAX)

endmodule
